// ===== hdl/sfa_pkg.sv =====
`default_nettype none

package sfa_pkg;

    localparam int FRAME_W  = 52;
    localparam int ADDR_W   = 64;
    localparam int SLOT_W   = 6;
    localparam int USABLE_W = 7;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_LOAD     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ALLOCATE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_REGIONS    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUT_OF_MEMORY = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [SLOT_W-1:0] entry_index;
        logic [ADDR_W-1:0] region_start;
        logic [ADDR_W-1:0] region_end;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame_number;
    } rsp_t;

    typedef logic [USABLE_W-1:0] usable_t;

endpackage

`default_nettype wire

// ===== hdl/sequential_frame_allocator.sv =====
// Bump allocator for physical frames over a table of usable memory regions.
// Requests arrive on the s_ channel (s_valid, s_ready, s_req) and every
// request gives exactly one response on the m_ channel (m_valid, m_ready,
// m_rsp). A load request stores one region's bounds as frame numbers, a
// start request rewinds the allocator to region 0 or, with no descriptors,
// is refused; an allocate request returns the next frame after the last.
// The number of usable descriptors is written on the cfg_ channel, which
// is always ready; it should only be changed while no request is in flight.
// Load, start and unknown requests are answered from the idle state. An
// allocate request checks the current region, then reads each later region
// until one has a frame or none is left; the region table is a single memory
// with one registered read per cycle. One request is in flight at a time.
// A finished response waits in an output register, so a stalled receiver
// does not hold up the next request; only a second response that finds the
// output register still full is parked until the receiver takes the first.
// Reset clears the control state, the allocator position and the descriptor
// count; the region table holds nothing defined until it has been loaded.
`default_nettype none

module sequential_frame_allocator #(
    parameter int MAX_REGIONS = 64,
    parameter int FRAME_SHIFT = 12
) (
    input  wire                logic aclk,
    input  wire                logic aresetn,
    input  wire                logic s_valid,
    output                     logic s_ready,
    input  wire  sfa_pkg::req_t      s_req,
    output                     logic m_valid,
    input  wire                logic m_ready,
    output       sfa_pkg::rsp_t      m_rsp,
    input  wire                logic cfg_valid,
    output                     logic cfg_ready,
    input  wire  sfa_pkg::usable_t   cfg_data
);

    localparam int FW    = sfa_pkg::FRAME_W;
    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = (IDX_W + 1 > sfa_pkg::USABLE_W + 1) ?
                           IDX_W + 1 : sfa_pkg::USABLE_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    sfa_pkg::rsp_t        m_rsp_reg, m_rsp_next;
    sfa_pkg::rsp_t        held_reg, held_next;
    sfa_pkg::usable_t     usable_reg, usable_next;
    logic [FW-1:0]        last_reg, last_next;
    logic                 none_given_reg, none_given_next;
    logic [IDX_W-1:0]     current_reg, current_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;

    logic [2*FW-1:0]      mem [MAX_REGIONS];
    logic [2*FW-1:0]      rdata_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [2*FW-1:0]      mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;

    logic                 accept;
    logic                 out_free;
    logic                 fin_valid;
    sfa_pkg::rsp_t        fin_rsp;
    logic [CNT_W-1:0]     slot_ext;
    logic [CNT_W-1:0]     limit_raw;
    logic [CNT_W-1:0]     limit;
    logic [CNT_W-1:0]     scan_next;
    logic [FW-1:0]        lo_frame;
    logic [FW-1:0]        hi_frame;
    logic                 found;
    logic [FW-1:0]        found_frame;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_rsp     = m_rsp_reg;
    assign cfg_ready = 1'b1;

    assign slot_ext  = CNT_W'(s_req.entry_index);
    assign limit_raw = (usable_reg == '0) ? '0 : CNT_W'(usable_reg) - CNT_W'(1);
    assign limit     = (limit_raw > CNT_W'(MAX_REGIONS)) ? CNT_W'(MAX_REGIONS) : limit_raw;
    assign scan_next = CNT_W'(rd_idx_reg) + CNT_W'(1);

    assign lo_frame  = rdata_reg[2*FW-1:FW];
    assign hi_frame  = rdata_reg[FW-1:0];

    always_comb begin
        found       = 1'b0;
        found_frame = lo_frame;
        if (none_given_reg || (last_reg < lo_frame)) begin
            found = 1'b1;
        end else if (last_reg < hi_frame) begin
            found       = 1'b1;
            found_frame = last_reg + FW'(1);
        end
    end

    always_comb begin
        state_next      = state_reg;
        m_valid_next    = m_valid_reg;
        m_rsp_next      = m_rsp_reg;
        held_next       = held_reg;
        usable_next     = usable_reg;
        last_next       = last_reg;
        none_given_next = none_given_reg;
        current_next    = current_reg;
        rd_idx_next     = rd_idx_reg;
        fin_valid       = 1'b0;
        fin_rsp         = '{status: sfa_pkg::STATUS_OK, frame_number: '0};
        mem_we          = 1'b0;
        mem_waddr       = slot_ext[IDX_W-1:0];
        mem_wdata       = {FW'(s_req.region_start >> FRAME_SHIFT),
                           FW'(s_req.region_end >> FRAME_SHIFT)};
        mem_re          = 1'b0;
        mem_raddr       = current_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_valid) begin
            usable_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_req.req_type)
                        sfa_pkg::REQ_LOAD: begin
                            mem_we    = (slot_ext < CNT_W'(MAX_REGIONS));
                            fin_valid = 1'b1;
                        end
                        sfa_pkg::REQ_START: begin
                            fin_valid = 1'b1;
                            if (usable_reg == '0) begin
                                fin_rsp.status = sfa_pkg::STATUS_NO_REGIONS;
                            end else begin
                                current_next    = '0;
                                last_next       = '0;
                                none_given_next = 1'b1;
                            end
                        end
                        sfa_pkg::REQ_ALLOCATE: begin
                            mem_re      = 1'b1;
                            mem_raddr   = current_reg;
                            rd_idx_next = current_reg;
                            state_next  = ST_CHECK;
                        end
                        default: begin
                            fin_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (found) begin
                    fin_valid            = 1'b1;
                    fin_rsp.frame_number = found_frame;
                    last_next            = found_frame;
                    none_given_next      = 1'b0;
                    current_next         = rd_idx_reg;
                end else if (scan_next < limit) begin
                    mem_re      = 1'b1;
                    mem_raddr   = scan_next[IDX_W-1:0];
                    rd_idx_next = scan_next[IDX_W-1:0];
                end else begin
                    fin_valid      = 1'b1;
                    fin_rsp.status = sfa_pkg::STATUS_OUT_OF_MEMORY;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rsp_next   = held_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin_valid) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_rsp_next   = fin_rsp;
                state_next   = ST_IDLE;
            end else begin
                held_next  = fin_rsp;
                state_next = ST_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            usable_reg     <= '0;
            last_reg       <= '0;
            none_given_reg <= 1'b1;
            current_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            usable_reg     <= usable_next;
            last_reg       <= last_next;
            none_given_reg <= none_given_next;
            current_reg    <= current_next;
        end
        m_rsp_reg  <= m_rsp_next;
        held_reg   <= held_next;
        rd_idx_reg <= rd_idx_next;
    end

    // A response that finds the output register occupied must be parked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fin_valid && !out_free |=> state_reg == ST_DONE && m_valid_reg)
        else $error("response lost while the output register was full");

    // Only a successful allocation carries a frame number.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_rsp_reg.status != sfa_pkg::STATUS_OK |->
            m_rsp_reg.frame_number == '0)
        else $error("failed request carries a frame number");

    // A successful allocation records the frame it hands out.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHECK && found |=>
            !none_given_reg && last_reg == $past(found_frame))
        else $error("allocated frame not recorded");

    // A parked response blocks new requests.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> !s_ready)
        else $error("request accepted while a response is parked");

endmodule

`default_nettype wire

// ===== test/sequential_frame_allocator_tb.sv =====
`default_nettype none

module sequential_frame_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SLOTS = 64;
    localparam int SHIFT = 12;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [sfa_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef logic [sfa_pkg::FRAME_W-1:0] frame_t;

    class allocation_tracker;
        int usable;
        frame_t region_lo[MAX_SLOTS];
        frame_t region_hi[MAX_SLOTS];
        bit loaded[MAX_SLOTS];
        frame_t last_given;
        bit none_given;
        int cur_region;
        sfa_pkg::rsp_t expected_q[$];
        int failures;

        function new();
            usable = 0;
            last_given = '0;
            none_given = 1'b1;
            cur_region = 0;
            failures = 0;
            foreach (loaded[i]) begin
                loaded[i] = 1'b0;
                region_lo[i] = '0;
                region_hi[i] = '0;
            end
        endfunction

        function void set_usable(int v);
            usable = v;
        endfunction

        function int scan_limit();
            int lim;
            lim = (usable > 0) ? usable - 1 : 0;
            if (lim > MAX_SLOTS) begin
                lim = MAX_SLOTS;
            end
            return lim;
        endfunction

        function bit next_frame(int idx, output frame_t f);
            f = '0;
            if (idx >= MAX_SLOTS) begin
                return 1'b0;
            end
            if (none_given || last_given < region_lo[idx]) begin
                f = region_lo[idx];
                return 1'b1;
            end
            if (last_given < region_hi[idx]) begin
                f = last_given + 1'b1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Returns the first table slot that an allocate request would read before it
        // has been loaded, or -1 when every slot it reads holds a region.
        function int unloaded_slot_for_allocate();
            frame_t f;
            int lim;
            if (!loaded[cur_region]) begin
                return cur_region;
            end
            if (next_frame(cur_region, f)) begin
                return -1;
            end
            lim = scan_limit();
            for (int i = cur_region + 1; i < lim; i++) begin
                if (!loaded[i]) begin
                    return i;
                end
                if (next_frame(i, f)) begin
                    return -1;
                end
            end
            return -1;
        endfunction

        function void note_request(sfa_pkg::req_t r);
            sfa_pkg::rsp_t e;
            frame_t f;
            int lim;
            bit found;
            e.status = sfa_pkg::STATUS_OK;
            e.frame_number = '0;
            case (r.req_type)
                sfa_pkg::REQ_LOAD: begin
                    region_lo[r.entry_index] = sfa_pkg::FRAME_W'(r.region_start >> SHIFT);
                    region_hi[r.entry_index] = sfa_pkg::FRAME_W'(r.region_end >> SHIFT);
                    loaded[r.entry_index] = 1'b1;
                end
                sfa_pkg::REQ_START: begin
                    if (usable < 1) begin
                        e.status = sfa_pkg::STATUS_NO_REGIONS;
                    end else begin
                        cur_region = 0;
                        last_given = '0;
                        none_given = 1'b1;
                    end
                end
                sfa_pkg::REQ_ALLOCATE: begin
                    if (next_frame(cur_region, f)) begin
                        last_given = f;
                        none_given = 1'b0;
                        e.frame_number = f;
                    end else begin
                        lim = scan_limit();
                        found = 1'b0;
                        for (int i = cur_region + 1; i < lim && !found; i++) begin
                            if (next_frame(i, f)) begin
                                cur_region = i;
                                last_given = f;
                                none_given = 1'b0;
                                e.frame_number = f;
                                found = 1'b1;
                            end
                        end
                        if (!found) begin
                            e.status = sfa_pkg::STATUS_OUT_OF_MEMORY;
                        end
                    end
                end
                default: begin
                end
            endcase
            expected_q.push_back(e);
        endfunction

        function void check_response(sfa_pkg::rsp_t got);
            sfa_pkg::rsp_t e;
            if (expected_q.size() == 0) begin
                $error("Response with no request outstanding: status %0d, frame 0x%0h",
                       got.status, got.frame_number);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                failures++;
            end
            if (got.frame_number !== e.frame_number) begin
                $error("frame_number: expected 0x%0h, got 0x%0h",
                       e.frame_number, got.frame_number);
                failures++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    sfa_pkg::req_t s_req = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sfa_pkg::rsp_t m_rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    sfa_pkg::usable_t cfg_data = '0;

    allocation_tracker tracker = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int unsigned requests_accepted = 0;
    int unsigned cycles = 0;

    sequential_frame_allocator uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req(s_req),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_rsp(m_rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_response(m_rsp);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [sfa_pkg::ADDR_W-1:0] frame_addr(frame_t f);
        return {f, 12'($urandom)};
    endfunction

    function automatic frame_t random_base();
        case ($urandom_range(3))
            0: return '0;
            1: return sfa_pkg::FRAME_W'($urandom_range(1, 1000));
            2: return sfa_pkg::FRAME_W'({$urandom, $urandom});
            default: return '1 - sfa_pkg::FRAME_W'($urandom_range(0, 200));
        endcase
    endfunction

    function automatic sfa_pkg::req_t make_load(int slot, frame_t lo, frame_t hi);
        sfa_pkg::req_t r;
        r.req_type = sfa_pkg::REQ_LOAD;
        r.entry_index = sfa_pkg::SLOT_W'(slot);
        r.region_start = frame_addr(lo);
        r.region_end = frame_addr(hi);
        return r;
    endfunction

    function automatic sfa_pkg::req_t make_random_load(int slot);
        frame_t lo;
        frame_t hi;
        lo = random_base();
        hi = lo + sfa_pkg::FRAME_W'($urandom_range(0, 8));
        if ($urandom_range(5) == 0) begin
            hi = sfa_pkg::FRAME_W'({$urandom, $urandom});
        end
        return make_load(slot, lo, hi);
    endfunction

    function automatic sfa_pkg::req_t make_cmd(logic [sfa_pkg::REQ_W-1:0] kind);
        sfa_pkg::req_t r;
        r.req_type = kind;
        r.entry_index = sfa_pkg::SLOT_W'($urandom);
        r.region_start = {$urandom, $urandom};
        r.region_end = {$urandom, $urandom};
        return r;
    endfunction

    task automatic send_request(sfa_pkg::req_t r);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req <= r;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(r);
        requests_accepted++;
    endtask

    task automatic wait_all_responses();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.expected_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_usable(int v);
        wait_all_responses();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= sfa_pkg::usable_t'(v);
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_usable(v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic allocate_frame();
        int slot;
        slot = tracker.unloaded_slot_for_allocate();
        while (slot >= 0) begin
            send_request(make_random_load(slot));
            slot = tracker.unloaded_slot_for_allocate();
        end
        send_request(make_cmd(sfa_pkg::REQ_ALLOCATE));
    endtask

    task automatic run_episode();
        int n;
        int k;
        int ops;
        int pick;
        frame_t cursor;
        frame_t lo;
        frame_t hi;
        case ($urandom_range(19))
            0: n = 0;
            1: n = 1;
            2: n = 64;
            3: n = 65;
            4: n = 127;
            5: n = 2;
            default: n = $urandom_range(2, 10);
        endcase
        write_usable(n);
        k = (n == 0) ? 1 : ((n > MAX_SLOTS) ? MAX_SLOTS : n);
        cursor = random_base();
        for (int i = 0; i < k; i++) begin
            lo = cursor + sfa_pkg::FRAME_W'($urandom_range(0, 3));
            hi = lo + sfa_pkg::FRAME_W'($urandom_range(0, 5));
            if ($urandom_range(11) == 0) begin
                hi = lo - sfa_pkg::FRAME_W'($urandom_range(1, 3));
            end
            if ($urandom_range(19) == 0) begin
                lo = sfa_pkg::FRAME_W'({$urandom, $urandom});
                hi = sfa_pkg::FRAME_W'({$urandom, $urandom});
            end
            send_request(make_load(i, lo, hi));
            cursor = hi + 1'b1;
        end
        send_request(make_cmd(sfa_pkg::REQ_START));
        ops = $urandom_range(8, 30);
        for (int i = 0; i < ops; i++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                allocate_frame();
            end else if (pick < 78) begin
                send_request(make_random_load($urandom_range(0, MAX_SLOTS - 1)));
            end else if (pick < 86) begin
                send_request(make_cmd(sfa_pkg::REQ_START));
            end else if (pick < 92) begin
                send_request(make_cmd(REQ_UNKNOWN));
            end else begin
                allocate_frame();
            end
            if ($urandom_range(199) == 0) begin
                wait_all_responses();
            end
        end
    endtask

    task automatic run_phase(int sender_idle, int receiver_idle, int unsigned quota);
        int unsigned target;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        target = requests_accepted + quota;
        while (requests_accepted < target) begin
            run_episode();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 60;

        // With no descriptors configured a start request is refused, and an unknown
        // request leaves everything as it was.
        send_request(make_cmd(sfa_pkg::REQ_START));
        send_request('1);
        send_request('0);
        // Allocation before any start begins at region 0 and gives frame 0 first.
        send_request(make_load(0, sfa_pkg::FRAME_W'(0), sfa_pkg::FRAME_W'(2)));
        repeat (4) allocate_frame();
        // A region starting above the last frame given yields its first frame even
        // though its end lies below its start.
        write_usable(3);
        send_request(make_load(1, sfa_pkg::FRAME_W'(16), sfa_pkg::FRAME_W'(0)));
        repeat (2) allocate_frame();
        send_request(make_cmd(sfa_pkg::REQ_START));
        allocate_frame();
        send_request(make_load(2, '1, '1));
        write_usable(4);
        repeat (4) allocate_frame();
        write_usable(0);
        send_request(make_cmd(sfa_pkg::REQ_START));
        allocate_frame();
        write_usable(1);
        send_request(make_cmd(sfa_pkg::REQ_START));
        allocate_frame();
        wait_all_responses();

        run_phase(34, 60, 550);
        wait_all_responses();
        run_phase(60, 34, 550);
        run_phase(0, 0, 550);

        wait_all_responses();
        repeat (100) @(posedge aclk);
        if (tracker.failures == 0 && tracker.expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
